// ===== design/rmhr_pkg.sv =====
package rmhr_pkg;

  localparam int unsigned WordW = 16;

  typedef enum logic [7:0] {
    PH_FRESH   = 8'b0000_0001,
    PH_START   = 8'b0000_0010,
    PH_IDLE    = 8'b0000_0100,
    PH_ACTIVE  = 8'b0000_1000,
    PH_CLEAR   = 8'b0001_0000,
    PH_GOTADDR = 8'b0010_0000,
    PH_WRITING = 8'b0100_0000,
    PH_FAULT   = 8'b1000_0000
  } phase_t;

  localparam logic [2:0] PC_IDLE    = 3'd0;
  localparam logic [2:0] PC_ACTIVE  = 3'd1;
  localparam logic [2:0] PC_CLEAR   = 3'd2;
  localparam logic [2:0] PC_GOTADDR = 3'd3;
  localparam logic [2:0] PC_WRITING = 3'd4;
  localparam logic [2:0] PC_DONE    = 3'd5;
  localparam logic [2:0] PC_FAULT   = 3'd6;

  localparam logic [2:0] LED_WHITE   = 3'd0;
  localparam logic [2:0] LED_GREEN   = 3'd1;
  localparam logic [2:0] LED_MAGENTA = 3'd2;
  localparam logic [2:0] LED_BLUE    = 3'd3;
  localparam logic [2:0] LED_YELLOW  = 3'd4;
  localparam logic [2:0] LED_RED     = 3'd5;

  localparam logic [1:0] LN_LOW    = 2'd0;
  localparam logic [1:0] LN_ADDR   = 2'd1;
  localparam logic [1:0] LN_IDLE   = 2'd2;
  localparam logic [1:0] LN_ACTIVE = 2'd3;

  localparam logic [WordW-1:0] SENSE_OFF  = 16'hffff;
  localparam logic [WordW-1:0] FAULT_EXIT = 16'd999;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  typedef enum logic [1:0] {
    SA_KEEP = 2'd0,
    SA_ONES = 2'd1,
    SA_WORD = 2'd2
  } sact_t;

  typedef struct packed {
    logic             kind;
    logic [2:0]       code;
    logic [WordW-1:0] count;
    logic [2:0]       led;
    sact_t            sact;
  } rec_t;

  typedef struct packed {
    phase_t           phase;
    logic [WordW-1:0] count;
    logic [1:0]       num;
    rec_t [2:0]       slot;
  } step_t;

  function automatic rec_t mk_status(logic [2:0] code, logic [WordW-1:0] count,
                                     logic [2:0] led);
    rec_t r;
    r.kind  = KIND_STATUS;
    r.code  = code;
    r.count = count;
    r.led   = led;
    r.sact  = SA_KEEP;
    return r;
  endfunction

  function automatic rec_t mk_idle();
    rec_t r;
    r.kind  = KIND_STATUS;
    r.code  = PC_IDLE;
    r.count = '0;
    r.led   = LED_GREEN;
    r.sact  = SA_ONES;
    return r;
  endfunction

  function automatic rec_t mk_data(logic [WordW-1:0] count);
    rec_t r;
    r.kind  = KIND_DATA;
    r.code  = PC_GOTADDR;
    r.count = count;
    r.led   = LED_BLUE;
    r.sact  = SA_WORD;
    return r;
  endfunction

endpackage

// ===== design/rmhr_decode.sv =====
module rmhr_decode (
  input  rmhr_pkg::phase_t              phase,
  input  logic [rmhr_pkg::WordW-1:0]    count,
  input  logic [1:0]                    lines,
  output rmhr_pkg::step_t               step
);

  logic [rmhr_pkg::WordW-1:0] cnt_inc;

  assign cnt_inc = count + rmhr_pkg::WordW'(1);

  always_comb begin
    step.phase = phase;
    step.count = cnt_inc;
    step.num   = 2'd0;
    step.slot  = '0;
    unique case (phase)
      rmhr_pkg::PH_FRESH: begin
        step.count   = '0;
        step.slot[0] = rmhr_pkg::mk_status(rmhr_pkg::PC_IDLE, '0, rmhr_pkg::LED_WHITE);
        if (lines == rmhr_pkg::LN_IDLE) begin
          step.slot[1] = rmhr_pkg::mk_idle();
          step.phase   = rmhr_pkg::PH_IDLE;
          step.num     = 2'd2;
        end else begin
          step.phase = rmhr_pkg::PH_START;
          step.num   = 2'd1;
        end
      end
      rmhr_pkg::PH_START: begin
        if (lines == rmhr_pkg::LN_IDLE) begin
          step.slot[0] = rmhr_pkg::mk_idle();
          step.phase   = rmhr_pkg::PH_IDLE;
          step.count   = '0;
          step.num     = 2'd1;
        end
      end
      rmhr_pkg::PH_IDLE: begin
        if (lines == rmhr_pkg::LN_ACTIVE) begin
          step.slot[0] = rmhr_pkg::mk_status(rmhr_pkg::PC_ACTIVE, cnt_inc,
                                             rmhr_pkg::LED_MAGENTA);
          step.phase   = rmhr_pkg::PH_ACTIVE;
          step.num     = 2'd1;
        end else if (lines != rmhr_pkg::LN_IDLE) begin
          step.slot[0] = rmhr_pkg::mk_status(rmhr_pkg::PC_FAULT, cnt_inc, rmhr_pkg::LED_RED);
          step.phase   = rmhr_pkg::PH_FAULT;
          step.num     = 2'd1;
        end
      end
      rmhr_pkg::PH_ACTIVE: begin
        unique case (lines)
          rmhr_pkg::LN_IDLE: begin
            step.slot[0] = rmhr_pkg::mk_status(rmhr_pkg::PC_CLEAR, cnt_inc,
                                               rmhr_pkg::LED_BLUE);
            step.phase   = rmhr_pkg::PH_CLEAR;
            step.num     = 2'd1;
          end
          rmhr_pkg::LN_ADDR: begin
            step.slot[0] = rmhr_pkg::mk_status(rmhr_pkg::PC_GOTADDR, cnt_inc,
                                               rmhr_pkg::LED_BLUE);
            step.slot[1] = rmhr_pkg::mk_data(cnt_inc);
            step.phase   = rmhr_pkg::PH_GOTADDR;
            step.num     = 2'd2;
          end
          rmhr_pkg::LN_LOW: begin
            step.slot[0] = rmhr_pkg::mk_status(rmhr_pkg::PC_FAULT, cnt_inc,
                                               rmhr_pkg::LED_RED);
            step.phase   = rmhr_pkg::PH_FAULT;
            step.num     = 2'd1;
          end
          default: ;
        endcase
      end
      rmhr_pkg::PH_CLEAR: begin
        unique case (lines)
          rmhr_pkg::LN_ACTIVE: begin
            step.slot[0] = rmhr_pkg::mk_status(rmhr_pkg::PC_ACTIVE, cnt_inc,
                                               rmhr_pkg::LED_MAGENTA);
            step.phase   = rmhr_pkg::PH_ACTIVE;
            step.num     = 2'd1;
          end
          rmhr_pkg::LN_LOW: begin
            // single step: address, data, then straight to fault
            step.slot[0] = rmhr_pkg::mk_status(rmhr_pkg::PC_GOTADDR, cnt_inc,
                                               rmhr_pkg::LED_BLUE);
            step.slot[1] = rmhr_pkg::mk_data(cnt_inc);
            step.slot[2] = rmhr_pkg::mk_status(rmhr_pkg::PC_FAULT, cnt_inc,
                                               rmhr_pkg::LED_RED);
            step.phase   = rmhr_pkg::PH_FAULT;
            step.num     = 2'd3;
          end
          rmhr_pkg::LN_ADDR: begin
            step.phase = rmhr_pkg::PH_FAULT;
          end
          default: ;
        endcase
      end
      rmhr_pkg::PH_GOTADDR: begin
        if (lines == rmhr_pkg::LN_ACTIVE) begin
          step.slot[0] = rmhr_pkg::mk_status(rmhr_pkg::PC_WRITING, cnt_inc,
                                             rmhr_pkg::LED_YELLOW);
          step.phase   = rmhr_pkg::PH_WRITING;
          step.num     = 2'd1;
        end else if (lines != rmhr_pkg::LN_ADDR) begin
          step.slot[0] = rmhr_pkg::mk_status(rmhr_pkg::PC_FAULT, cnt_inc, rmhr_pkg::LED_RED);
          step.phase   = rmhr_pkg::PH_FAULT;
          step.num     = 2'd1;
        end
      end
      rmhr_pkg::PH_WRITING: begin
        if (lines == rmhr_pkg::LN_IDLE) begin
          step.slot[0] = rmhr_pkg::mk_status(rmhr_pkg::PC_DONE, cnt_inc,
                                             rmhr_pkg::LED_YELLOW);
          step.slot[1] = rmhr_pkg::mk_idle();
          step.phase   = rmhr_pkg::PH_IDLE;
          step.count   = '0;
          step.num     = 2'd2;
        end else if (lines != rmhr_pkg::LN_ACTIVE) begin
          step.slot[0] = rmhr_pkg::mk_status(rmhr_pkg::PC_FAULT, cnt_inc, rmhr_pkg::LED_RED);
          step.phase   = rmhr_pkg::PH_FAULT;
          step.num     = 2'd1;
        end
      end
      default: begin
        // fault wait: samples are not counted
        step.count = count;
        if (lines == rmhr_pkg::LN_IDLE) begin
          step.slot[0] = rmhr_pkg::mk_status(rmhr_pkg::PC_FAULT, rmhr_pkg::FAULT_EXIT,
                                             rmhr_pkg::LED_RED);
          step.slot[1] = rmhr_pkg::mk_idle();
          step.phase   = rmhr_pkg::PH_IDLE;
          step.count   = '0;
          step.num     = 2'd2;
        end
      end
    endcase
  end

endmodule

// ===== design/rmhr_store.sv =====
module rmhr_store #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic                        rd_en,
  input  logic [ADDR_BITS-1:0]        addr,
  input  logic [rmhr_pkg::WordW-1:0]  wdata,
  output logic [rmhr_pkg::WordW-1:0]  rdata
);

  localparam int unsigned Depth = 1 << ADDR_BITS;

  logic [rmhr_pkg::WordW-1:0] mem [Depth];
  logic [rmhr_pkg::WordW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/rope_memory_handshake_responder_unit.sv =====
// Handshake responder for a word-addressed read-only store.
// Input channel (in_*): a beat with in_mode = 1 writes in_load_word into the
// store at {in_addr_high, in_addr_low}; it gives no result. A beat with
// in_mode = 0 is one sample of the two handshake lines and may give up to
// three result records on the out_* channel, the last one flagged by
// out_last_record. Both channels use valid/ready.
// A sample's first record goes through the record buffer, loaded when the
// input beat is taken, and then the output register, loaded when it is free
// or being read. Throughput is one input beat per cycle while each sample
// gives at most one record and the receiver does not stall; a sample that
// gives more records holds the input while the record buffer drains them into
// the output register, one per cycle while it is read. Loads are taken one
// per cycle whenever the record buffer is free or draining its last record.
// The store read for an address is a single registered read issued at input.
// Reset (rst_n low, synchronous) puts the sequencer in its fresh start state,
// clears the sample count, drives the sense lines to all ones and empties
// the record buffer and output register; store contents are not cleared.
// When the receiver stalls, the output register holds its record, the record
// buffer fills behind it, and then in_ready drops until the stall clears.
module rope_memory_handshake_responder_unit #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [1:0]  in_lines,
  input  logic [7:0]  in_addr_high,
  input  logic [7:0]  in_addr_low,
  input  logic [15:0] in_load_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_record_kind,
  output logic [2:0]  out_phase_code,
  output logic [15:0] out_sample_count,
  output logic [1:0]  out_line_value,
  output logic [15:0] out_word_address,
  output logic [15:0] out_word_value,
  output logic [15:0] out_sense_out,
  output logic [2:0]  out_led_colour,
  output logic        out_last_record
);

  rmhr_pkg::phase_t              phase_r;
  logic [rmhr_pkg::WordW-1:0]    count_r;
  logic [rmhr_pkg::WordW-1:0]    sense_r;
  logic [rmhr_pkg::WordW-1:0]    sense_nxt;
  rmhr_pkg::step_t               step;

  logic                          plan_v_r;
  logic [1:0]                    plan_num_r;
  logic [1:0]                    idx_r;
  rmhr_pkg::rec_t [2:0]          plan_slot_r;
  logic [1:0]                    plan_lines_r;
  logic [ADDR_BITS-1:0]          plan_addr_r;

  logic                          out_valid_r;
  logic                          out_kind_r;
  logic [2:0]                    out_code_r;
  logic [rmhr_pkg::WordW-1:0]    out_count_r;
  logic [1:0]                    out_lines_r;
  logic [rmhr_pkg::WordW-1:0]    out_addr_r;
  logic [rmhr_pkg::WordW-1:0]    out_word_r;
  logic [2:0]                    out_led_r;
  logic                          out_last_r;

  logic                          in_acc;
  logic                          smp_acc;
  logic                          ld_acc;
  logic [15:0]                   addr_full;
  logic [ADDR_BITS-1:0]          addr;
  logic [rmhr_pkg::WordW-1:0]    rd_word;
  rmhr_pkg::rec_t                cur_rec;
  logic                          move;
  logic                          last;

  assign addr_full = {in_addr_high, in_addr_low};
  assign addr      = addr_full[ADDR_BITS-1:0];
  assign in_acc    = in_valid & in_ready;
  assign smp_acc   = in_acc & ~in_mode;
  assign ld_acc    = in_acc & in_mode;

  rmhr_decode u_decode (
    .phase (phase_r),
    .count (count_r),
    .lines (in_lines),
    .step  (step)
  );

  rmhr_store #(
    .ADDR_BITS (ADDR_BITS)
  ) u_store (
    .clk   (clk),
    .wr_en (ld_acc),
    .rd_en (smp_acc),
    .addr  (addr),
    .wdata (in_load_word),
    .rdata (rd_word)
  );

  assign cur_rec  = plan_slot_r[idx_r];
  assign move     = plan_v_r & (~out_valid_r | out_ready);
  assign last     = (idx_r == (plan_num_r - 2'd1));
  assign in_ready = ~plan_v_r | (move & last);

  always_comb begin
    unique case (cur_rec.sact)
      rmhr_pkg::SA_ONES: sense_nxt = rmhr_pkg::SENSE_OFF;
      rmhr_pkg::SA_WORD: sense_nxt = ~rd_word;
      default:           sense_nxt = sense_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= rmhr_pkg::PH_FRESH;
      count_r     <= '0;
      sense_r     <= rmhr_pkg::SENSE_OFF;
      plan_v_r    <= 1'b0;
      plan_num_r  <= 2'd0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (smp_acc) begin
        phase_r <= step.phase;
        count_r <= step.count;
      end
      if (smp_acc && (step.num != 2'd0)) begin
        plan_v_r   <= 1'b1;
        plan_num_r <= step.num;
        idx_r      <= 2'd0;
      end else if (move && last) begin
        plan_v_r <= 1'b0;
        idx_r    <= 2'd0;
      end else if (move) begin
        idx_r <= idx_r + 2'd1;
      end
      if (move) begin
        sense_r     <= sense_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (smp_acc) begin
      plan_slot_r  <= step.slot;
      plan_lines_r <= in_lines;
      plan_addr_r  <= addr;
    end
    if (move) begin
      out_kind_r  <= cur_rec.kind;
      out_code_r  <= cur_rec.code;
      out_count_r <= cur_rec.count;
      out_lines_r <= plan_lines_r;
      out_led_r   <= cur_rec.led;
      out_last_r  <= last;
      if (cur_rec.kind == rmhr_pkg::KIND_DATA) begin
        out_addr_r <= rmhr_pkg::WordW'(plan_addr_r);
        out_word_r <= rd_word;
      end else begin
        out_addr_r <= '0;
        out_word_r <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_record_kind  = out_kind_r;
  assign out_phase_code   = out_code_r;
  assign out_sample_count = out_count_r;
  assign out_line_value   = out_lines_r;
  assign out_word_address = out_addr_r;
  assign out_word_value   = out_word_r;
  assign out_sense_out    = sense_r;
  assign out_led_colour   = out_led_r;
  assign out_last_record  = out_last_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    plan_v_r |-> (idx_r < plan_num_r))
    else $error("record index beyond buffered record count");

  a_data_sense: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == rmhr_pkg::KIND_DATA)) |-> (sense_r == ~out_word_r))
    else $error("data beat sense lines do not match inverted word");

  a_idle_sense: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_led_r == rmhr_pkg::LED_GREEN)) |->
      (sense_r == rmhr_pkg::SENSE_OFF && out_count_r == '0))
    else $error("idle entry beat without released sense lines");

  a_sample_waits_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (smp_acc && plan_v_r) |-> (move && last))
    else $error("sample taken while records still pending");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned RANDOM_BEATS = 500;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned LONG_HOLD    = 300;

  // line values of the directed samples, first sample in the top bits
  localparam logic [49:0] DIRECTED = {
    rmhr_pkg::LN_LOW, rmhr_pkg::LN_ADDR, rmhr_pkg::LN_IDLE, rmhr_pkg::LN_IDLE,
    rmhr_pkg::LN_ACTIVE, rmhr_pkg::LN_ADDR, rmhr_pkg::LN_ADDR, rmhr_pkg::LN_ACTIVE,
    rmhr_pkg::LN_IDLE, rmhr_pkg::LN_ACTIVE, rmhr_pkg::LN_IDLE, rmhr_pkg::LN_ACTIVE,
    rmhr_pkg::LN_IDLE, rmhr_pkg::LN_LOW, rmhr_pkg::LN_LOW, rmhr_pkg::LN_IDLE,
    rmhr_pkg::LN_ACTIVE, rmhr_pkg::LN_IDLE, rmhr_pkg::LN_ADDR, rmhr_pkg::LN_IDLE,
    rmhr_pkg::LN_LOW, rmhr_pkg::LN_IDLE, rmhr_pkg::LN_ACTIVE, rmhr_pkg::LN_LOW,
    rmhr_pkg::LN_IDLE
  };

  typedef struct packed {
    logic        mode;
    logic [1:0]  lines;
    logic [7:0]  addr_high;
    logic [7:0]  addr_low;
    logic [15:0] load_word;
  } beat_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  code;
    logic [15:0] count;
    logic [1:0]  lines;
    logic [15:0] addr;
    logic [15:0] word;
    logic [15:0] sense;
    logic [2:0]  led;
    logic        last;
  } tb_rec_t;

  class responder_scoreboard;
    rmhr_pkg::phase_t phase;
    logic [15:0] sample_cnt;
    logic [15:0] sense;
    logic [15:0] rope [logic [15:0]];
    tb_rec_t     expected [$];
    tb_rec_t     burst [$];
    int          errors;
    int          checked;
    int          data_recs;
    int          fault_recs;

    function new();
      phase      = rmhr_pkg::PH_FRESH;
      sample_cnt = '0;
      sense      = rmhr_pkg::SENSE_OFF;
      errors     = 0;
      checked    = 0;
      data_recs  = 0;
      fault_recs = 0;
    endfunction

    function void add(logic kind, logic [2:0] code, logic [15:0] count, logic [1:0] ln,
                      logic [15:0] a, logic [15:0] w, logic [2:0] led);
      tb_rec_t r;
      r.kind  = kind;
      r.code  = code;
      r.count = count;
      r.lines = ln;
      r.addr  = a;
      r.word  = w;
      r.sense = sense;
      r.led   = led;
      r.last  = 1'b0;
      burst.push_back(r);
    endfunction

    function void enter_idle(logic [1:0] ln);
      sample_cnt = '0;
      sense      = rmhr_pkg::SENSE_OFF;
      phase      = rmhr_pkg::PH_IDLE;
      add(rmhr_pkg::KIND_STATUS, rmhr_pkg::PC_IDLE, 16'd0, ln, 16'd0, 16'd0,
          rmhr_pkg::LED_GREEN);
    endfunction

    function void enter_fault(logic [1:0] ln);
      phase = rmhr_pkg::PH_FAULT;
      add(rmhr_pkg::KIND_STATUS, rmhr_pkg::PC_FAULT, sample_cnt, ln, 16'd0, 16'd0,
          rmhr_pkg::LED_RED);
    endfunction

    function void read_word(logic [1:0] ln, logic [15:0] a);
      logic [15:0] w;
      add(rmhr_pkg::KIND_STATUS, rmhr_pkg::PC_GOTADDR, sample_cnt, ln, 16'd0, 16'd0,
          rmhr_pkg::LED_BLUE);
      w = rope.exists(a) ? rope[a] : 16'd0;
      sense = ~w;
      add(rmhr_pkg::KIND_DATA, rmhr_pkg::PC_GOTADDR, sample_cnt, ln, a, w,
          rmhr_pkg::LED_BLUE);
      phase = rmhr_pkg::PH_GOTADDR;
    endfunction

    function void note_beat(beat_t b);
      logic [15:0] a;
      logic [1:0]  ln;
      a  = {b.addr_high, b.addr_low};
      ln = b.lines;
      if (b.mode) begin
        rope[a] = b.load_word;
        return;
      end
      burst.delete();
      if (phase != rmhr_pkg::PH_FRESH && phase != rmhr_pkg::PH_FAULT)
        sample_cnt = sample_cnt + 16'd1;
      case (phase)
        rmhr_pkg::PH_FRESH: begin
          sample_cnt = '0;
          add(rmhr_pkg::KIND_STATUS, rmhr_pkg::PC_IDLE, 16'd0, ln, 16'd0, 16'd0,
              rmhr_pkg::LED_WHITE);
          if (ln == rmhr_pkg::LN_IDLE) enter_idle(ln);
          else phase = rmhr_pkg::PH_START;
        end
        rmhr_pkg::PH_START: begin
          if (ln == rmhr_pkg::LN_IDLE) enter_idle(ln);
        end
        rmhr_pkg::PH_IDLE: begin
          if (ln == rmhr_pkg::LN_ACTIVE) begin
            phase = rmhr_pkg::PH_ACTIVE;
            add(rmhr_pkg::KIND_STATUS, rmhr_pkg::PC_ACTIVE, sample_cnt, ln, 16'd0, 16'd0,
                rmhr_pkg::LED_MAGENTA);
          end else if (ln != rmhr_pkg::LN_IDLE) begin
            enter_fault(ln);
          end
        end
        rmhr_pkg::PH_ACTIVE: begin
          if (ln == rmhr_pkg::LN_IDLE) begin
            phase = rmhr_pkg::PH_CLEAR;
            add(rmhr_pkg::KIND_STATUS, rmhr_pkg::PC_CLEAR, sample_cnt, ln, 16'd0, 16'd0,
                rmhr_pkg::LED_BLUE);
          end else if (ln == rmhr_pkg::LN_ADDR) begin
            read_word(ln, a);
          end else if (ln == rmhr_pkg::LN_LOW) begin
            enter_fault(ln);
          end
        end
        rmhr_pkg::PH_CLEAR: begin
          if (ln == rmhr_pkg::LN_ACTIVE) begin
            phase = rmhr_pkg::PH_ACTIVE;
            add(rmhr_pkg::KIND_STATUS, rmhr_pkg::PC_ACTIVE, sample_cnt, ln, 16'd0, 16'd0,
                rmhr_pkg::LED_MAGENTA);
          end else if (ln == rmhr_pkg::LN_LOW) begin
            read_word(ln, a);
            enter_fault(ln);
          end else if (ln == rmhr_pkg::LN_ADDR) begin
            phase = rmhr_pkg::PH_FAULT;
          end
        end
        rmhr_pkg::PH_GOTADDR: begin
          if (ln == rmhr_pkg::LN_ACTIVE) begin
            phase = rmhr_pkg::PH_WRITING;
            add(rmhr_pkg::KIND_STATUS, rmhr_pkg::PC_WRITING, sample_cnt, ln, 16'd0, 16'd0,
                rmhr_pkg::LED_YELLOW);
          end else if (ln != rmhr_pkg::LN_ADDR) begin
            enter_fault(ln);
          end
        end
        rmhr_pkg::PH_WRITING: begin
          if (ln == rmhr_pkg::LN_IDLE) begin
            add(rmhr_pkg::KIND_STATUS, rmhr_pkg::PC_DONE, sample_cnt, ln, 16'd0, 16'd0,
                rmhr_pkg::LED_YELLOW);
            enter_idle(ln);
          end else if (ln != rmhr_pkg::LN_ACTIVE) begin
            enter_fault(ln);
          end
        end
        default: begin
          if (ln == rmhr_pkg::LN_IDLE) begin
            add(rmhr_pkg::KIND_STATUS, rmhr_pkg::PC_FAULT, rmhr_pkg::FAULT_EXIT, ln, 16'd0,
                16'd0, rmhr_pkg::LED_RED);
            enter_idle(ln);
          end
        end
      endcase
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) expected.push_back(burst[i]);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task cmp(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("record %0d %s got %0h want %0h", checked, name, got, want));
    endtask

    task check_record(tb_rec_t got);
      tb_rec_t want;
      checked++;
      if (expected.size() == 0) begin
        report($sformatf("record %0d arrived with nothing pending (code %0d, count %0d)",
                         checked, got.code, got.count));
        return;
      end
      want = expected.pop_front();
      if (want.kind == rmhr_pkg::KIND_DATA) data_recs++;
      if (want.code == rmhr_pkg::PC_FAULT) fault_recs++;
      cmp("record_kind", 16'(got.kind), 16'(want.kind));
      cmp("phase_code", 16'(got.code), 16'(want.code));
      cmp("sample_count", got.count, want.count);
      cmp("line_value", 16'(got.lines), 16'(want.lines));
      cmp("word_address", got.addr, want.addr);
      cmp("word_value", got.word, want.word);
      cmp("sense_out", got.sense, want.sense);
      cmp("led_colour", 16'(got.led), 16'(want.led));
      cmp("last_record", 16'(got.last), 16'(want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = 1'b0;
  logic [1:0]  in_lines = '0;
  logic [7:0]  in_addr_high = '0;
  logic [7:0]  in_addr_low = '0;
  logic [15:0] in_load_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_record_kind;
  logic [2:0]  out_phase_code;
  logic [15:0] out_sample_count;
  logic [1:0]  out_line_value;
  logic [15:0] out_word_address;
  logic [15:0] out_word_value;
  logic [15:0] out_sense_out;
  logic [2:0]  out_led_colour;
  logic        out_last_record;

  responder_scoreboard sb = new();
  logic [15:0] loaded [$];
  logic [1:0]  plan [$];
  int unsigned cycles = 0;
  int          samples_sent = 0;
  int          loads_sent = 0;
  bit          tx_fast = 1'b0;
  bit          rx_fast = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  rope_memory_handshake_responder_unit #(
    .ADDR_BITS(16)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_lines(in_lines),
    .in_addr_high(in_addr_high),
    .in_addr_low(in_addr_low),
    .in_load_word(in_load_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_record_kind(out_record_kind),
    .out_phase_code(out_phase_code),
    .out_sample_count(out_sample_count),
    .out_line_value(out_line_value),
    .out_word_address(out_word_address),
    .out_word_value(out_word_value),
    .out_sense_out(out_sense_out),
    .out_led_colour(out_led_colour),
    .out_last_record(out_last_record)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d records pending", cycles, sb.expected.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic drive_beat(beat_t b);
    int gap;
    if ((samples_sent + loads_sent) % 40 == 0) tx_fast = ($urandom_range(0, 3) == 0);
    gap = tx_fast ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode      = b.mode;
    in_lines     = b.lines;
    in_addr_high = b.addr_high;
    in_addr_low  = b.addr_low;
    in_load_word = b.load_word;
    in_valid     = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_beat(b);
    if (b.mode) loads_sent++;
    else samples_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_load(logic [15:0] a, logic [15:0] w);
    beat_t b;
    b.mode      = 1'b1;
    b.lines     = 2'($urandom);
    b.addr_high = a[15:8];
    b.addr_low  = a[7:0];
    b.load_word = w;
    drive_beat(b);
    loaded.push_back(a);
  endtask

  // a sample that would read the store always points at a loaded word
  task automatic send_sample(logic [1:0] ln);
    beat_t       b;
    logic [15:0] a;
    a = 16'($urandom);
    if (((sb.phase == rmhr_pkg::PH_ACTIVE) && (ln == rmhr_pkg::LN_ADDR)) ||
        ((sb.phase == rmhr_pkg::PH_CLEAR) && (ln == rmhr_pkg::LN_LOW)))
      a = loaded[$urandom_range(0, loaded.size() - 1)];
    b.mode      = 1'b0;
    b.lines     = ln;
    b.addr_high = a[15:8];
    b.addr_low  = a[7:0];
    b.load_word = 16'($urandom);
    drive_beat(b);
  endtask

  task automatic drain();
    while (sb.expected.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic void push_run(logic [1:0] ln, int maxn);
    repeat ($urandom_range(0, maxn)) plan.push_back(ln);
  endfunction

  function automatic void extend_plan();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      repeat ($urandom_range(1, 6)) plan.push_back(2'($urandom));
      return;
    end
    if (sb.phase != rmhr_pkg::PH_IDLE) begin
      if (r < 30) plan.push_back(2'($urandom));
      else plan.push_back((sb.phase == rmhr_pkg::PH_CLEAR) ? rmhr_pkg::LN_ADDR
                                                           : rmhr_pkg::LN_IDLE);
      return;
    end
    push_run(rmhr_pkg::LN_IDLE, 3);
    plan.push_back(rmhr_pkg::LN_ACTIVE);
    push_run(rmhr_pkg::LN_ACTIVE, 3);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        plan.push_back(rmhr_pkg::LN_ADDR);
        push_run(rmhr_pkg::LN_ADDR, 3);
        plan.push_back(rmhr_pkg::LN_ACTIVE);
        push_run(rmhr_pkg::LN_ACTIVE, 3);
        plan.push_back(rmhr_pkg::LN_IDLE);
      end
      5, 6: begin
        plan.push_back(rmhr_pkg::LN_IDLE);
        push_run(rmhr_pkg::LN_IDLE, 3);
        plan.push_back(rmhr_pkg::LN_ACTIVE);
        plan.push_back(rmhr_pkg::LN_ADDR);
        push_run(rmhr_pkg::LN_ADDR, 2);
        plan.push_back(rmhr_pkg::LN_ACTIVE);
        plan.push_back(rmhr_pkg::LN_IDLE);
      end
      7: begin
        plan.push_back(rmhr_pkg::LN_IDLE);
        push_run(rmhr_pkg::LN_IDLE, 3);
        plan.push_back(rmhr_pkg::LN_LOW);
        push_run(rmhr_pkg::LN_LOW, 2);
        push_run(rmhr_pkg::LN_ACTIVE, 1);
        plan.push_back(rmhr_pkg::LN_IDLE);
      end
      8: begin
        plan.push_back(rmhr_pkg::LN_IDLE);
        plan.push_back(rmhr_pkg::LN_ADDR);
        plan.push_back(rmhr_pkg::LN_IDLE);
      end
      default: begin
        plan.push_back(rmhr_pkg::LN_ADDR);
        repeat ($urandom_range(20, 60)) plan.push_back(rmhr_pkg::LN_ADDR);
        plan.push_back(rmhr_pkg::LN_ACTIVE);
        plan.push_back(rmhr_pkg::LN_IDLE);
      end
    endcase
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, plan.size() - 1);
      plan[k] = 2'($urandom);
    end
  endfunction

  function automatic logic [1:0] next_lines();
    if (plan.size() == 0) extend_plan();
    return plan.pop_front();
  endfunction

  initial begin : stimulus
    logic [15:0] w;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_load(16'h0000, 16'h0000);
    send_load(16'hffff, 16'hffff);
    send_load(16'hff00, 16'hc350);
    send_load(16'h00ff, 16'h00ff);
    for (int i = 0; i < 25; i++) send_sample(DIRECTED[49 - 2*i -: 2]);
    drain();

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == 120) hold_req = 1'b1;
      if (i == 300) drain();
      if ($urandom_range(0, 99) < 15) begin
        case ($urandom_range(0, 9))
          0: w = 16'h0000;
          1: w = 16'hffff;
          default: w = 16'($urandom);
        endcase
        send_load(16'($urandom), w);
      end else begin
        send_sample(next_lines());
      end
    end
    in_valid = 1'b0;

    while (sb.expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d samples and %0d loads, %0d records checked", samples_sent,
             loads_sent, sb.checked);
    $display("of those %0d carried store data and %0d were fault records", sb.data_recs,
             sb.fault_recs);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : receiver
    int      n;
    tb_rec_t got;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      // long stall so the record buffer fills and the input backs up
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (sb.checked % 40 == 0) rx_fast = ($urandom_range(0, 3) == 0);
      n = rx_fast ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.kind  = out_record_kind;
      got.code  = out_phase_code;
      got.count = out_sample_count;
      got.lines = out_line_value;
      got.addr  = out_word_address;
      got.word  = out_word_value;
      got.sense = out_sense_out;
      got.led   = out_led_colour;
      got.last  = out_last_record;
      sb.check_record(got);
      @(negedge clk);
    end
  end

endmodule
